/* design/edge_window_tachometer_macros.svh */
// assertion macros for the edge window tachometer
`ifndef EDGE_WINDOW_TACHOMETER_MACROS_SVH
`define EDGE_WINDOW_TACHOMETER_MACROS_SVH

`ifndef SYNTHESIS

`define EWT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define EWT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define EWT_ASSERT(lbl, prop, msg)

`define EWT_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

/* design/ewt_pkg.sv */
// types, constants and register indexes shared by the tachometer modules
package ewt_pkg;

  localparam int unsigned TimeBits    = 63;
  localparam int unsigned CountBits   = 13;
  localparam int unsigned SizeM1Bits  = 12;
  localparam int unsigned DivBits     = 11;
  localparam int unsigned SpeedBits   = 32;
  localparam int unsigned NumerBits   = 58;
  localparam int unsigned DenomBits   = TimeBits + DivBits;
  localparam int unsigned ShiftBits   = DenomBits + SpeedBits - 1;
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 13;

  localparam int unsigned MinWindow = 2;
  localparam int unsigned MaxWindow = 4096;

  localparam logic [45:0] NsMilliPerMin = 46'd60000000000000;
  localparam logic [SpeedBits-1:0] FloorReset = 32'd10000000;
  localparam logic [CountBits-1:0] WindowReset = 13'd5;

  localparam logic [CfgIdxBits-1:0] CfgWindowEdges   = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgEdgesPerRev   = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgAlternateOnly = 2'd2;

  localparam logic EvEdge    = 1'b0;
  localparam logic EvTimeout = 1'b1;

  typedef struct packed {
    logic                event_kind;
    logic [TimeBits-1:0] event_time;
  } in_item_t;

  typedef struct packed {
    logic                 no_signal;
    logic [SpeedBits-1:0] speed_milli_rpm;
    logic [SpeedBits-1:0] peak_milli_rpm;
    logic [SpeedBits-1:0] floor_milli_rpm;
  } result_t;

  typedef struct packed {
    logic                  timeout;
    logic                  alternate;
    logic [SizeM1Bits-1:0] size_m1;
    logic [DivBits-1:0]    divisor;
    logic [TimeBits-1:0]   duration;
  } job_t;

endpackage

/* design/ewt_jobq.sv */
// two-entry request queue between window tracking and the rpm unit
module ewt_jobq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ewt_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output ewt_pkg::job_t data_o,
  output logic          empty_o
);
  import ewt_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d    = do_push ? !wr_q : wr_q;
    rd_d    = do_pop ? !rd_q : rd_q;
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

endmodule

/* design/ewt_outq.sv */
// two-entry result queue in front of the result ports
module ewt_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ewt_pkg::result_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output ewt_pkg::result_t data_o,
  output logic             empty_o
);
  import ewt_pkg::*;

  result_t    mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d    = do_push ? !wr_q : wr_q;
    rd_d    = do_pop ? !rd_q : rd_q;
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

endmodule

/* design/ewt_front.sv */
// configuration registers and window tracking, issues rpm requests
module ewt_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ewt_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [ewt_pkg::CfgDataBits-1:0]    cfg_wdata_i,
  input  logic                               push_i,
  input  ewt_pkg::in_item_t                  item_i,
  input  logic                               jq_full_i,
  output ewt_pkg::job_t                      job_o,
  output logic                               job_push_o
);
  import ewt_pkg::*;

  logic [CountBits-1:0] win_q;
  logic [DivBits-1:0]   epr_q;
  logic                 alt_q;

  logic [TimeBits-1:0]  start_q, start_d;
  logic [CountBits-1:0] count_q, count_d;
  logic                 skip_q, skip_d;

  logic                 accept;
  logic                 take;
  logic [CountBits-1:0] win_size;
  logic [CountBits-1:0] count_inc;
  logic [TimeBits-1:0]  start_sel;
  logic [DivBits-1:0]   divisor;

  assign accept = push_i && !jq_full_i;

  always_comb begin
    if (win_q < CountBits'(MinWindow)) begin
      win_size = CountBits'(MinWindow);
    end else if (win_q > CountBits'(MaxWindow)) begin
      win_size = CountBits'(MaxWindow);
    end else begin
      win_size = win_q;
    end
  end

  always_comb begin
    if (alt_q || (epr_q == '0)) begin
      divisor = DivBits'(1);
    end else begin
      divisor = epr_q;
    end
  end

  always_comb begin
    start_d    = start_q;
    count_d    = count_q;
    skip_d     = skip_q;
    job_push_o = 1'b0;
    take       = 1'b0;
    start_sel  = (count_q == '0) ? item_i.event_time : start_q;
    count_inc  = count_q + CountBits'(1);
    job_o.timeout   = 1'b0;
    job_o.alternate = alt_q;
    job_o.size_m1   = SizeM1Bits'(win_size - CountBits'(1));
    job_o.divisor   = divisor;
    job_o.duration  = item_i.event_time - start_sel;
    if (accept) begin
      if (item_i.event_kind == EvTimeout) begin
        job_o.timeout = 1'b1;
        job_push_o    = 1'b1;
        count_d       = '0;
        skip_d        = 1'b1;
      end else begin
        take = !alt_q || skip_q;
        if (alt_q) begin
          skip_d = !skip_q;
        end
        if (take) begin
          if (count_q == '0) begin
            start_d = item_i.event_time;
          end
          if (count_inc >= win_size) begin
            job_push_o = 1'b1;
            count_d    = '0;
            skip_d     = 1'b1;
          end else begin
            count_d = count_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WindowReset;
      epr_q <= DivBits'(1);
      alt_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgWindowEdges:   win_q <= cfg_wdata_i[CountBits-1:0];
        CfgEdgesPerRev:   epr_q <= cfg_wdata_i[DivBits-1:0];
        CfgAlternateOnly: alt_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      count_q <= '0;
      skip_q  <= 1'b1;
    end else begin
      start_q <= start_d;
      count_q <= count_d;
      skip_q  <= skip_d;
    end
  end

endmodule

/* design/ewt_back.sv */
// rpm unit: shift-add products, restoring divide, peak and floor tracking
`include "edge_window_tachometer_macros.svh"

module ewt_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ewt_pkg::job_t    job_i,
  input  logic             job_empty_i,
  output logic             job_pop_o,
  input  logic             outq_full_i,
  output ewt_pkg::result_t res_o,
  output logic             res_push_o
);
  import ewt_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StChk  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [4:0]            cnt_q, cnt_d;
  logic                  alt_q, alt_d;
  logic [SizeM1Bits-1:0] msel_q, msel_d;
  logic [SizeM1Bits-1:0] dsel_q, dsel_d;
  logic [TimeBits-1:0]   dur_q, dur_d;
  logic [NumerBits-1:0]  num_q, num_d;
  logic [DenomBits-1:0]  den_q, den_d;
  logic [ShiftBits-1:0]  dsh_q, dsh_d;
  logic [SpeedBits-1:0]  quo_q, quo_d;
  logic [SpeedBits-1:0]  peak_q, peak_d;
  logic [SpeedBits-1:0]  floor_q, floor_d;

  logic                  sat;
  logic                  ge;
  logic [SpeedBits-1:0]  new_peak;
  logic [SpeedBits-1:0]  new_floor;

  assign sat = (den_q[DenomBits-1:NumerBits-SpeedBits] == '0)
            && (num_q >= {den_q[NumerBits-SpeedBits-1:0], {SpeedBits{1'b0}}});
  assign ge  = (dsh_q[ShiftBits-1:NumerBits] == '0) && (num_q >= dsh_q[NumerBits-1:0]);

  assign new_peak  = (!alt_q && (quo_q > peak_q)) ? quo_q : peak_q;
  assign new_floor = (!alt_q && (quo_q < floor_q)) ? quo_q : floor_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    alt_d      = alt_q;
    msel_d     = msel_q;
    dsel_d     = dsel_q;
    dur_d      = dur_q;
    num_d      = num_q;
    den_d      = den_q;
    dsh_d      = dsh_q;
    quo_d      = quo_q;
    peak_d     = peak_q;
    floor_d    = floor_q;
    job_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o.no_signal       = 1'b0;
    res_o.speed_milli_rpm = quo_q;
    res_o.peak_milli_rpm  = new_peak;
    res_o.floor_milli_rpm = new_floor;
    unique case (state_q)
      StIdle: begin
        if (!job_empty_i && !outq_full_i) begin
          job_pop_o = 1'b1;
          if (job_i.timeout) begin
            res_push_o            = 1'b1;
            res_o.no_signal       = 1'b1;
            res_o.speed_milli_rpm = '0;
            res_o.peak_milli_rpm  = peak_q;
            res_o.floor_milli_rpm = floor_q;
          end else begin
            alt_d   = job_i.alternate;
            msel_d  = job_i.size_m1;
            dsel_d  = {1'b0, job_i.divisor};
            dur_d   = job_i.duration;
            num_d   = '0;
            den_d   = '0;
            cnt_d   = 5'(SizeM1Bits - 1);
            state_d = StMul;
          end
        end
      end
      // msb-first shift-add of both products
      StMul: begin
        num_d  = {num_q[NumerBits-2:0], 1'b0}
               + (msel_q[SizeM1Bits-1] ? NumerBits'(NsMilliPerMin) : '0);
        den_d  = {den_q[DenomBits-2:0], 1'b0}
               + (dsel_q[SizeM1Bits-1] ? DenomBits'(dur_q) : '0);
        msel_d = {msel_q[SizeM1Bits-2:0], 1'b0};
        dsel_d = {dsel_q[SizeM1Bits-2:0], 1'b0};
        cnt_d  = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          state_d = StChk;
        end
      end
      // quotient of 2^32 or more, or zero duration, saturates
      StChk: begin
        if (sat) begin
          quo_d   = '1;
          state_d = StDone;
        end else begin
          dsh_d   = {den_q, {(SpeedBits-1){1'b0}}};
          quo_d   = '0;
          cnt_d   = 5'(SpeedBits - 1);
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (ge) begin
          num_d = num_q - dsh_q[NumerBits-1:0];
        end
        quo_d = {quo_q[SpeedBits-2:0], ge};
        dsh_d = {1'b0, dsh_q[ShiftBits-1:1]};
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          state_d = StDone;
        end
      end
      StDone: begin
        res_push_o = 1'b1;
        peak_d     = new_peak;
        floor_d    = new_floor;
        state_d    = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    msel_q <= msel_d;
    dsel_q <= dsel_d;
    dur_q  <= dur_d;
    num_q  <= num_d;
    den_q  <= den_d;
    dsh_q  <= dsh_d;
    quo_q  <= quo_d;
    cnt_q  <= cnt_d;
    alt_q  <= alt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      peak_q  <= '0;
      floor_q <= FloorReset;
    end else begin
      state_q <= state_d;
      peak_q  <= peak_d;
      floor_q <= floor_d;
    end
  end

  `EWT_ASSERT_NEVER(a_pop_while_busy, job_pop_o && (state_q != StIdle), "pop while busy")
  `EWT_ASSERT_NEVER(a_push_into_full, res_push_o && outq_full_i, "push into full queue")
  `EWT_ASSERT(a_measure_starts, (job_pop_o && !job_i.timeout) |=> (state_q == StMul), "stuck")

endmodule

/* design/edge_window_tachometer.sv */
// Edge window tachometer. Edge and timeout events enter through a push/full queue port and
// are classified at once, one per cycle while the two-entry request queue has room. A filled
// window or a timeout becomes one request to the rpm unit, which handles one request at a
// time: a timeout result is written at dispatch, and a speed result passes through dispatch,
// 12 shift-add steps forming 60e12*(edges-1) and divisor*duration, a saturation check, 32
// restoring divide steps and write-back, skipping the divide steps when the speed saturates.
// Results wait in a two-entry queue read through empty/pop. Configuration writes take effect
// on the next edge.
module edge_window_tachometer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ewt_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [ewt_pkg::CfgDataBits-1:0] cfg_wdata_i,
  input  logic                            push,
  output logic                            full,
  input  ewt_pkg::in_item_t               in_item_i,
  output logic                            empty,
  input  logic                            pop,
  output ewt_pkg::result_t                result_o
);
  import ewt_pkg::*;

  job_t    job_in, job_out;
  logic    job_push, job_pop, jq_full, jq_empty;
  result_t res;
  logic    res_push, oq_full;

  assign full = jq_full;

  ewt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .item_i      (in_item_i),
    .jq_full_i   (jq_full),
    .job_o       (job_in),
    .job_push_o  (job_push)
  );

  ewt_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (jq_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (jq_empty)
  );

  ewt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .job_empty_i (jq_empty),
    .job_pop_o   (job_pop),
    .outq_full_i (oq_full),
    .res_o       (res),
    .res_push_o  (res_push)
  );

  ewt_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (oq_full),
    .pop_i   (pop),
    .data_o  (result_o),
    .empty_o (empty)
  );

endmodule
